### rtl/assert_macros.svh
// Assertion macros for the checker file of the frame type classifier.
// No dependencies; include this by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mftc_pkg.sv
// Types and constants for the MPEG-4 frame type classifier.
// No dependencies; used by the top level and its checker.
package mftc_pkg;

  // Start code values that follow the 00 00 01 prefix.
  localparam logic [7:0] SC_VOS = 8'hB0;
  localparam logic [7:0] SC_GOV = 8'hB3;
  localparam logic [7:0] SC_VOP = 8'hB6;

  // Three-byte start code prefix.
  localparam logic [23:0] SC_PREFIX = 24'h000001;

  // Reset value of the parameter frame size limit.
  localparam logic [15:0] PARAM_SIZE_RESET = 16'd1024;

  // Width of the size limit register.
  localparam int LIMIT_W = 16;

  // Key decision of the current frame.
  typedef enum logic [1:0] {
    DEC_NONE   = 2'd0,
    DEC_KEY    = 2'd1,
    DEC_NOTKEY = 2'd2
  } key_dec_t;

  // Frame type codes on the result.
  localparam logic [1:0] FT_KEY   = 2'd0;
  localparam logic [1:0] FT_DATA  = 2'd1;
  localparam logic [1:0] FT_PARAM = 2'd2;

  // One input request: a payload byte and the end-of-frame flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [1:0] frame_kind;
    logic       vop_found;
    logic       key_found;
  } out_item_t;

endpackage

### rtl/mpeg4_frame_type_classifier.sv
// A last byte waits in the input register until the result register is free; its
// result is then registered there and stays offered while the result is stalled.
// Throughput: one byte per cycle; the input register, the frame state and the
// result register each advance every cycle unless a last byte waits on a
// stalled result. Reset clears the frame state, empties both registers and
// loads the size limit with 1024.
// Top level of the frame type classifier; depends on mftc_pkg.
module mpeg4_frame_type_classifier #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [15:0]          cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mftc_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mftc_pkg::out_item_t  out_item
);
  import mftc_pkg::*;

  localparam int CMP_W = (LENGTH_BITS > LIMIT_W) ? LENGTH_BITS : LIMIT_W;

  // Configuration register.
  logic [LIMIT_W-1:0] param_size_limit;

  // Input register.
  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_fire;
  logic     in_accept;

  // Frame state and its next values.
  logic [23:0]            recent_bytes, recent_bytes_next;
  logic [1:0]             recent_count, recent_count_next;
  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;
  logic                   vop_seen, vop_seen_next;
  key_dec_t               key_decision, key_decision_next;
  logic                   vop_type_pending, vop_type_pending_next;

  // Result computation.
  logic          start_code;
  logic          out_free;
  logic          below_limit;
  out_item_t     result;

  // The user must write the size limit only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      param_size_limit <= PARAM_SIZE_RESET;
    end else if (cfg_write_en) begin
      param_size_limit <= cfg_write_data;
    end
  end

  // Handshake: a last byte needs a free result register, other bytes never wait.
  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && (!s1_item.last_byte || out_free);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= in_item;
    end
  end

  // Start code scan and key decision for the byte in the input register.
  always_comb begin
    start_code            = (recent_count == 2'd3) && (recent_bytes == SC_PREFIX);
    byte_count_next       = (byte_count != '1) ? byte_count + 1'b1 : byte_count;
    vop_seen_next         = vop_seen;
    key_decision_next     = key_decision;
    vop_type_pending_next = vop_type_pending;

    if (vop_type_pending) begin
      key_decision_next     = (s1_item.data_byte[7:6] == 2'b00) ? DEC_KEY : DEC_NOTKEY;
      vop_type_pending_next = 1'b0;
    end else if (start_code) begin
      if (s1_item.data_byte == SC_VOP) begin
        vop_seen_next = 1'b1;
        if (key_decision == DEC_NONE && !s1_item.last_byte) begin
          vop_type_pending_next = 1'b1;
        end
      end else if ((s1_item.data_byte == SC_VOS || s1_item.data_byte == SC_GOV) &&
                   key_decision == DEC_NONE) begin
        key_decision_next = DEC_KEY;
      end
    end

    recent_bytes_next = {recent_bytes[15:0], s1_item.data_byte};
    recent_count_next = (recent_count != 2'd3) ? recent_count + 2'd1 : recent_count;
  end

  // Frame classification from the updated state.
  always_comb begin
    below_limit = CMP_W'(byte_count_next) < CMP_W'(param_size_limit);
    if (vop_seen_next) begin
      result.frame_kind = (key_decision_next == DEC_KEY) ? FT_KEY : FT_DATA;
    end else begin
      result.frame_kind = below_limit ? FT_PARAM : FT_DATA;
    end
    result.vop_found = vop_seen_next;
    result.key_found = (key_decision_next == DEC_KEY);
  end

  // Frame state: updated per byte, cleared after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes     <= '0;
      recent_count     <= '0;
      byte_count       <= '0;
      vop_seen         <= 1'b0;
      key_decision     <= DEC_NONE;
      vop_type_pending <= 1'b0;
    end else if (s1_fire) begin
      if (s1_item.last_byte) begin
        recent_bytes     <= '0;
        recent_count     <= '0;
        byte_count       <= '0;
        vop_seen         <= 1'b0;
        key_decision     <= DEC_NONE;
        vop_type_pending <= 1'b0;
      end else begin
        recent_bytes     <= recent_bytes_next;
        recent_count     <= recent_count_next;
        byte_count       <= byte_count_next;
        vop_seen         <= vop_seen_next;
        key_decision     <= key_decision_next;
        vop_type_pending <= vop_type_pending_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.last_byte) begin
      out_item <= result;
    end
  end

endmodule

### rtl/mftc_checker.sv
// Port-level checks for the frame type classifier and their bind statement.
// Depends on mftc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mftc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input mftc_pkg::out_item_t  out_item
);
  import mftc_pkg::*;

  // Result fields under short names.
  logic [1:0] kind;
  logic       vop;
  logic       key;

  assign kind = out_item.frame_kind;
  assign vop  = out_item.vop_found;
  assign key  = out_item.key_found;

  // A stalled result stays offered.
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")

  // A key frame always comes from a VOP with a key decision.
  `CHK_SAME(a_key_flags, clk, rst, out_valid && kind == FT_KEY, key && vop, "key flags missing")

  // A parameter frame never holds a VOP.
  `CHK_SAME(a_param_novop, clk, rst, out_valid && kind == FT_PARAM, !vop, "parameter with VOP")

  // A data frame with a VOP was not decided as key.
  `CHK_SAME(a_data_nokey, clk, rst, out_valid && kind == FT_DATA && vop, !key, "data marked key")

  // Only the three defined frame types appear.
  `CHK_SAME(a_type_range, clk, rst, out_valid, kind <= FT_PARAM, "undefined frame type")

endmodule

bind mpeg4_frame_type_classifier mftc_checker u_mftc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
